// ===== hw/rtl/plt_pkg.sv =====
// Shared constants and codes for the process lifecycle tracker.
// No dependencies; imported by every module of the block.
package plt_pkg;

  localparam int SLOTS_DEF    = 512;
  localparam int PID_BITS_DEF = 22;

  localparam int UID_W     = 32;
  localparam int APP_W     = 17;
  localparam int SLOT_OUT_W = 9;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [UID_W-1:0] APP_UID_FLOOR_RST = 32'd10000;
  localparam logic [APP_W-1:0] ISO_FLOOR_RST     = 17'd90000;
  localparam logic [APP_W:0]   APP_MODULUS       = 18'd100000;
  localparam logic [UID_W-1:0] UID_NONE          = '1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_APP_UID_FLOOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ISO_FLOOR     = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_FORK = 2'd0,
    KIND_FREE = 2'd1,
    KIND_UID  = 2'd2,
    KIND_RSVD = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    OUT_IGNORED           = 3'd0,
    OUT_TRACKED           = 3'd1,
    OUT_ALREADY           = 3'd2,
    OUT_FULL              = 3'd3,
    OUT_RELEASED          = 3'd4,
    OUT_NOT_TRACKED       = 3'd5,
    OUT_SPECIALIZED       = 3'd6,
    OUT_NOT_SPECIALIZABLE = 3'd7
  } outcome_t;

endpackage

// ===== hw/rtl/plt_cell.sv =====
// One table slot of the tracker: pid, uid and specialized flag, plus one
// registered stage of the search token that walks the row. Uses plt_pkg.
module plt_cell
  import plt_pkg::*;
#(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int PID_BITS = PID_BITS_DEF,
  parameter int IDX      = 0,
  localparam int IDX_W   = $clog2(SLOTS),
  localparam int LINK_W  = 4 + 2 * IDX_W + UID_W,
  localparam int CMD_W   = 3 + IDX_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [PID_BITS-1:0] key,
  input  logic [UID_W-1:0]    wr_uid,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [LINK_W-1:0]   link_in,
  output logic [LINK_W-1:0]   link_out
);

  typedef struct packed {
    logic             tok;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic [UID_W-1:0] hit_uid;
    logic             hit_spec;
    logic             free_hit;
    logic [IDX_W-1:0] free_idx;
  } link_t;

  typedef struct packed {
    logic             claim;
    logic             release_slot;
    logic             special;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  link_t lin, link_r, link_nxt;
  cmd_t  cmd_s;
  logic [PID_BITS-1:0] pid_r;
  logic [UID_W-1:0]    uid_r;
  logic                spec_r;
  logic                sel;

  assign lin      = link_in;
  assign cmd_s    = cmd;
  assign link_out = link_r;
  assign sel      = (cmd_s.idx == MY_IDX);

  // Lowest match wins: a hit set upstream passes through untouched
  always_comb begin
    link_nxt = lin;
    if (lin.tok) begin
      if (!lin.hit && pid_r == key) begin
        link_nxt.hit      = 1'b1;
        link_nxt.hit_idx  = MY_IDX;
        link_nxt.hit_uid  = uid_r;
        link_nxt.hit_spec = spec_r;
      end
      if (!lin.free_hit && pid_r == '0) begin
        link_nxt.free_hit = 1'b1;
        link_nxt.free_idx = MY_IDX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r.tok <= 1'b0;
      pid_r      <= '0;
    end else begin
      link_r <= link_nxt;
      if (sel && cmd_s.claim) begin
        pid_r <= key;
      end else if (sel && cmd_s.release_slot) begin
        pid_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel && cmd_s.claim) begin
      uid_r  <= UID_NONE;
      spec_r <= 1'b0;
    end else if (sel && cmd_s.special) begin
      uid_r  <= wr_uid;
      spec_r <= 1'b1;
    end
  end

endmodule

// ===== hw/rtl/plt_mod_unit.sv =====
// Remainder of a 32-bit uid by 100000 in three registered stages.
// 100000 = 32 * 3125: the low five bits pass through, the upper 27 bits are
// reduced by 3125 with a reciprocal multiply. Uses plt_pkg for widths.
module plt_mod_unit
  import plt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [UID_W-1:0] uid,
  output logic             done,
  output logic [APP_W-1:0] rem
);

  localparam int LO_W     = 5;
  localparam int HI_W     = UID_W - LO_W;
  localparam int REM_HI_W = APP_W - LO_W;
  localparam int RECIP_W  = 28;
  localparam int SHIFT    = 39;
  localparam int PROD_W   = HI_W + RECIP_W;
  localparam int QUO_W    = PROD_W - SHIFT;
  // ceil(2^39 / 3125); exact quotient for every 27-bit dividend
  localparam logic [RECIP_W-1:0] RECIP   = 28'd175921861;
  localparam logic [HI_W-1:0]    DIV_ODD = 27'd3125;

  logic [HI_W-1:0]   hi_r;
  logic [LO_W-1:0]   lo_r;
  logic [PROD_W-1:0] prod_r;
  logic [APP_W-1:0]  rem_r;
  logic              mul_v_r;
  logic              sub_v_r;
  logic              done_r;
  logic [QUO_W-1:0]  quo;
  logic [HI_W-1:0]   rem_hi;

  assign quo    = prod_r[PROD_W-1:SHIFT];
  assign rem_hi = hi_r - HI_W'(quo) * DIV_ODD;

  assign done = done_r;
  assign rem  = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
      sub_v_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      mul_v_r <= go;
      sub_v_r <= mul_v_r;
      if (go) begin
        done_r <= 1'b0;
      end else if (sub_v_r) begin
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      hi_r <= uid[UID_W-1:LO_W];
      lo_r <= uid[LO_W-1:0];
    end
    if (mul_v_r) begin
      prod_r <= PROD_W'(hi_r) * PROD_W'(RECIP);
    end
    if (sub_v_r) begin
      rem_r <= {rem_hi[REM_HI_W-1:0], lo_r};
    end
  end

endmodule

// ===== hw/rtl/process_lifecycle_tracker.sv =====
// Process lifecycle tracker: a row of SLOTS cells searched by a walking token.
// The token crosses one cell per cycle, and the app id remainder overlaps it;
// the result strobe follows DECIDE once both are done. A new transaction is
// not taken while busy; start is taken again in the strobe cycle. Reset:
// floors return to 10000 / 90000, every slot is free. Uses plt_pkg, plt_cell
// and plt_mod_unit. The receiver cannot stall.
module process_lifecycle_tracker
  import plt_pkg::*;
#(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int PID_BITS = PID_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic [PID_BITS-1:0]   in_pid,
  input  logic                  in_is_leader,
  input  logic                  in_from_parent_service,
  input  logic [UID_W-1:0]      in_new_uid,
  output logic                  out_valid,
  output logic [2:0]            out_outcome,
  output logic [PID_BITS-1:0]   out_pid_out,
  output logic [UID_W-1:0]      out_uid_out,
  output logic [APP_W-1:0]      out_app_id,
  output logic [SLOT_OUT_W-1:0] out_slot_index,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int LINK_W = 4 + 2 * IDX_W + UID_W;
  localparam int CMD_W  = 3 + IDX_W;

  typedef struct packed {
    logic             tok;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic [UID_W-1:0] hit_uid;
    logic             hit_spec;
    logic             free_hit;
    logic [IDX_W-1:0] free_idx;
  } link_t;

  typedef struct packed {
    logic             claim;
    logic             release_slot;
    logic             special;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LAUNCH,
    S_SCAN,
    S_DECIDE
  } state_t;

  state_t state_r;

  logic [LINK_W-1:0] link [SLOTS+1];
  link_t launch, chain_end, res_r;
  cmd_t  cmd;
  logic  scan_done_r;

  logic [KIND_W-1:0]   kind_r;
  logic [PID_BITS-1:0] pid_r;
  logic                leader_r;
  logic                svc_r;
  logic [UID_W-1:0]    uid_r;

  logic [UID_W-1:0] uid_floor_r;
  logic [APP_W-1:0] iso_floor_r;

  logic             mod_done;
  logic [APP_W-1:0] mod_rem;
  logic             accept;

  outcome_t         dec_outcome;
  logic [UID_W-1:0] dec_uid;
  logic [APP_W-1:0] dec_app;
  logic [IDX_W-1:0] dec_slot;

  logic                  out_valid_r;
  outcome_t              out_outcome_r;
  logic [PID_BITS-1:0]   out_pid_r;
  logic [UID_W-1:0]      out_uid_r;
  logic [APP_W-1:0]      out_app_r;
  logic [SLOT_OUT_W-1:0] out_slot_r;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    launch     = '0;
    launch.tok = (state_r == S_LAUNCH);
  end
  assign link[0]   = launch;
  assign chain_end = link[SLOTS];

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    plt_cell #(
      .SLOTS   (SLOTS),
      .PID_BITS(PID_BITS),
      .IDX     (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .key     (pid_r),
      .wr_uid  (uid_r),
      .cmd     (cmd),
      .link_in (link[i]),
      .link_out(link[i+1])
    );
  end

  plt_mod_unit u_mod (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (accept),
    .uid  (in_new_uid),
    .done (mod_done),
    .rem  (mod_rem)
  );

  // Final decision once the token has left the row and the remainder is ready
  always_comb begin
    dec_outcome = OUT_IGNORED;
    dec_uid     = '0;
    dec_app     = '0;
    dec_slot    = '0;
    cmd         = '0;
    if (pid_r != '0) begin
      case (kind_t'(kind_r))
        KIND_FORK: begin
          if (leader_r && svc_r) begin
            if (res_r.hit) begin
              dec_outcome = OUT_ALREADY;
              dec_slot    = res_r.hit_idx;
            end else if (res_r.free_hit) begin
              dec_outcome = OUT_TRACKED;
              dec_slot    = res_r.free_idx;
              cmd.claim   = 1'b1;
              cmd.idx     = res_r.free_idx;
            end else begin
              dec_outcome = OUT_FULL;
            end
          end
        end
        KIND_FREE: begin
          if (leader_r) begin
            if (res_r.hit) begin
              dec_outcome      = OUT_RELEASED;
              dec_uid          = res_r.hit_uid;
              dec_slot         = res_r.hit_idx;
              cmd.release_slot = 1'b1;
              cmd.idx          = res_r.hit_idx;
            end else begin
              dec_outcome = OUT_NOT_TRACKED;
            end
          end
        end
        KIND_UID: begin
          if (uid_r >= uid_floor_r && mod_rem < iso_floor_r) begin
            if (!res_r.hit) begin
              dec_outcome = OUT_NOT_TRACKED;
            end else if (res_r.hit_spec) begin
              dec_outcome = OUT_NOT_SPECIALIZABLE;
              dec_slot    = res_r.hit_idx;
            end else begin
              dec_outcome = OUT_SPECIALIZED;
              dec_uid     = uid_r;
              dec_app     = mod_rem;
              dec_slot    = res_r.hit_idx;
              cmd.special = 1'b1;
              cmd.idx     = res_r.hit_idx;
            end
          end
        end
        default: begin
          dec_outcome = OUT_IGNORED;
        end
      endcase
    end
    if (state_r != S_DECIDE) begin
      cmd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_done_r <= 1'b0;
      out_valid_r <= 1'b0;
      uid_floor_r <= APP_UID_FLOOR_RST;
      iso_floor_r <= ISO_FLOOR_RST;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_APP_UID_FLOOR: uid_floor_r <= cfg_data[UID_W-1:0];
          CFG_ISO_FLOOR:     iso_floor_r <= cfg_data[APP_W-1:0];
          default:           uid_floor_r <= uid_floor_r;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_LAUNCH;
          end
        end
        S_LAUNCH: begin
          scan_done_r <= 1'b0;
          state_r     <= S_SCAN;
        end
        S_SCAN: begin
          if (chain_end.tok) begin
            scan_done_r <= 1'b1;
          end
          if (scan_done_r && mod_done) begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          out_valid_r   <= 1'b1;
          out_outcome_r <= dec_outcome;
          out_pid_r     <= pid_r;
          out_uid_r     <= dec_uid;
          out_app_r     <= dec_app;
          out_slot_r    <= SLOT_OUT_W'(dec_slot);
          state_r       <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Transaction payload and scan result; no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r   <= in_kind;
      pid_r    <= in_pid;
      leader_r <= in_is_leader;
      svc_r    <= in_from_parent_service;
      uid_r    <= in_new_uid;
    end
    if (state_r == S_SCAN && chain_end.tok) begin
      res_r <= chain_end;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_outcome    = out_outcome_r;
  assign out_pid_out    = out_pid_r;
  assign out_uid_out    = out_uid_r;
  assign out_app_id     = out_app_r;
  assign out_slot_index = out_slot_r;

endmodule

// ===== hw/rtl/plt_checker.sv =====
// Port-level assertions for process_lifecycle_tracker, bound to the top level.
// Uses plt_pkg outcome codes.
module plt_checker
  import plt_pkg::*;
#(
  parameter int PID_BITS = PID_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_valid,
  input logic [2:0]            out_outcome,
  input logic [UID_W-1:0]      out_uid_out,
  input logic [APP_W-1:0]      out_app_id,
  input logic [SLOT_OUT_W-1:0] out_slot_index
);

  // Taken transaction keeps the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accepted transaction");

  // A result ends a busy period and is a single-cycle strobe
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) && !busy)
    else $error("result strobe outside a busy period end");

  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_app_id_only_special: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outcome != OUT_SPECIALIZED |-> out_app_id == '0)
    else $error("app id set on a non-specialize result");

  a_no_slot_when_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_outcome == OUT_IGNORED || out_outcome == OUT_FULL ||
                  out_outcome == OUT_NOT_TRACKED)
    |-> out_slot_index == '0 && out_uid_out == '0)
    else $error("slot or uid reported on a result that touches no slot");

endmodule

bind process_lifecycle_tracker plt_checker #(
  .PID_BITS(PID_BITS)
) u_plt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_outcome   (out_outcome),
  .out_uid_out   (out_uid_out),
  .out_app_id    (out_app_id),
  .out_slot_index(out_slot_index)
);
